// File: hdl/error_function_approx_top_macros.svh
// Assertion macros for the error function pipeline.
// Used by error_function_approx_top; expects i_clk and i_rst_n in scope.
`ifndef ERROR_FUNCTION_APPROX_TOP_MACROS_SVH
`define ERROR_FUNCTION_APPROX_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERFA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ERFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/erfa_pkg.sv
// Package for the error function pipeline: constants, stage record, rounding helpers.
// No dependencies.
`timescale 1ns / 1ps

package erfa_pkg;

    localparam int NSTG = 31;

    localparam logic signed [23:0] C_A1 = 24'sd267208;
    localparam logic signed [23:0] C_A2 = -24'sd298316;
    localparam logic signed [23:0] C_A3 = 24'sd1490460;
    localparam logic signed [23:0] C_A4 = -24'sd1523740;
    localparam logic signed [23:0] C_A5 = 24'sd1112964;
    localparam logic [18:0] C_P      = 19'd343504;
    localparam logic [19:0] C_LN2    = 20'd726817;
    localparam logic [20:0] C_LOG2E  = 21'd1512775;
    localparam logic [20:0] C_ONE    = 21'd1048576;
    localparam logic [15:0] C_LIMIT  = 16'd16384;

    localparam logic [20:0] C_POW2 [8] = '{
        21'd741455, 21'd881744, 21'd961548, 21'd1004120,
        21'd1026107, 21'd1037281, 21'd1042913, 21'd1045741
    };

    typedef struct packed {
        logic              neg;
        logic              big;
        logic [13:0]       mag;
        logic [32:0]       pm;
        logic [27:0]       sq;
        logic [21:0]       den;
        logic [21:0]       rem;
        logic [20:0]       quo;
        logic [48:0]       vprod;
        logic [4:0]        n;
        logic [19:0]       f;
        logic [41:0]       eprod;
        logic [31:0]       rlprod;
        logic [20:0]       rl;
        logic [20:0]       e;
        logic [41:0]       cprod;
        logic [20:0]       ex;
        logic signed [47:0] hp;
        logic [15:0]       res;
    } t_stage;

    function automatic logic [47:0] f_rnd_u(input logic [47:0] p);
        return (p + 48'd524288) >> 20;
    endfunction

    function automatic logic signed [47:0] f_rnd_s(input logic signed [47:0] p);
        if (p >= 0) begin
            return (p + 48'sd524288) >>> 20;
        end
        return (p + 48'sd524287) >>> 20;
    endfunction

endpackage

// File: hdl/erfa_if.sv
// Request channel interfaces for the error function pipeline.
// No dependencies.
`timescale 1ns / 1ps

interface erfa_x_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] x_value;
    modport source(output valid, output x_value, input ready);
    modport sink(input valid, input x_value, output ready);
endinterface

interface erfa_erf_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] erf_value;
    modport source(output valid, output erf_value, input ready);
    modport sink(input valid, input erf_value, output ready);
endinterface

// File: hdl/error_function_approx_top.sv
// Throughput: one request per cycle unless output back-pressure has filled the pipeline;
// the 21-stage restoring quotient unit sets the depth.
// Each stage takes a new request when it is empty or its successor moves, so bubbles close up.
// Reset clears all stage valid bits; payload registers are not reset.
// Depends on erfa_pkg, erfa_if and error_function_approx_top_macros.svh.
`timescale 1ns / 1ps

module error_function_approx_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    erfa_x_if.sink         i_x,
    erfa_erf_if.source     o_erf
);
    import erfa_pkg::*;
    `include "error_function_approx_top_macros.svh"

    t_stage            r_stg [NSTG];
    t_stage            n_stg [NSTG];
    logic [NSTG-1:0]   r_vld;
    logic [NSTG:0]     rdy;

    always_comb begin
        rdy[NSTG] = o_erf.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign i_x.ready       = rdy[0];
    assign o_erf.valid     = r_vld[NSTG-1];
    assign o_erf.erf_value = r_stg[NSTG-1].res;

    always_comb begin
        logic [16:0]        mag17;
        logic [22:0]        r2;
        logic [24:0]        v;
        logic [20:0]        ecur;
        logic [21:0]        esum;
        logic signed [23:0] s;
        logic signed [47:0] s48;
        logic signed [47:0] t48;
        logic signed [27:0] y;
        logic signed [27:0] q;
        logic [15:0]        mres;
        n_stg[0] = r_stg[0];
        for (int k = 1; k < NSTG; k++) begin
            n_stg[k] = r_stg[k-1];
        end

        mag17 = i_x.x_value[15] ? 17'(-$signed({i_x.x_value[15], i_x.x_value}))
                                : 17'({1'b0, i_x.x_value});
        n_stg[0].neg = i_x.x_value[15];
        n_stg[0].big = mag17 >= 17'd16384;
        n_stg[0].mag = mag17[13:0];

        n_stg[1].pm = 33'(r_stg[0].mag) * 33'(C_P);
        n_stg[1].sq = 28'(r_stg[0].mag) * 28'(r_stg[0].mag);

        n_stg[2].den   = 22'(C_ONE) + 22'((r_stg[1].pm + 33'd2048) >> 12);
        n_stg[2].vprod = 49'(r_stg[1].sq) * 49'(C_LOG2E);
        n_stg[2].rem   = 22'd524288;
        n_stg[2].quo   = '0;

        for (int j = 0; j < 21; j++) begin
            r2 = {r_stg[j+2].rem, r_stg[j+2].den[21-j]};
            if (r2 >= 23'(r_stg[j+2].den)) begin
                n_stg[j+3].rem = 22'(r2 - 23'(r_stg[j+2].den));
                n_stg[j+3].quo = {r_stg[j+2].quo[19:0], 1'b1};
            end else begin
                n_stg[j+3].rem = r2[21:0];
                n_stg[j+3].quo = {r_stg[j+2].quo[19:0], 1'b0};
            end
        end

        v = 25'((r_stg[2].vprod + 49'd8388608) >> 24);
        n_stg[3].n     = v[24:20];
        n_stg[3].f     = v[19:0];
        n_stg[3].eprod = 42'd1 << 40;

        for (int i = 0; i < 8; i++) begin
            ecur = 21'(f_rnd_u(48'(r_stg[i+3].eprod)));
            n_stg[i+4].eprod = 42'(ecur) *
                (r_stg[i+3].f[19-i] ? 42'(C_POW2[i]) : 42'(C_ONE));
        end
        n_stg[4].rlprod = 32'(r_stg[3].f[11:0]) * 32'(C_LN2);
        n_stg[5].rl     = 21'(f_rnd_u(48'(r_stg[4].rlprod)));

        n_stg[12].e     = 21'(f_rnd_u(48'(r_stg[11].eprod)));
        n_stg[12].cprod = 42'(n_stg[12].e) * 42'(r_stg[11].rl);
        n_stg[13].e     = r_stg[12].e - 21'(f_rnd_u(48'(r_stg[12].cprod)));
        esum = 22'(r_stg[13].e) + ((22'd1 << r_stg[13].n) >> 1);
        n_stg[14].ex = 21'(esum >> r_stg[13].n);

        t48 = 48'(r_stg[23].quo);
        n_stg[24].hp = 48'(C_A5) * t48;
        for (int h = 0; h < 4; h++) begin
            t48 = 48'(r_stg[h+24].quo);
            case (h)
                0: s = 24'(f_rnd_s(r_stg[h+24].hp)) + C_A4;
                1: s = 24'(f_rnd_s(r_stg[h+24].hp)) + C_A3;
                2: s = 24'(f_rnd_s(r_stg[h+24].hp)) + C_A2;
                default: s = 24'(f_rnd_s(r_stg[h+24].hp)) + C_A1;
            endcase
            s48 = 48'(s);
            n_stg[h+25].hp = s48 * t48;
        end
        s   = 24'(f_rnd_s(r_stg[28].hp));
        s48 = 48'(s);
        n_stg[29].hp = s48 * $signed(48'(r_stg[28].ex));

        y = 28'sd1048576 - 28'(f_rnd_s(r_stg[29].hp));
        q = (y < 0) ? ((y + 28'sd31) >>> 6) : ((y + 28'sd32) >>> 6);
        if (q < 0) begin
            mres = '0;
        end else if (q > 28'sd16384) begin
            mres = C_LIMIT;
        end else begin
            mres = q[15:0];
        end
        if (r_stg[29].big) begin
            mres = C_LIMIT;
        end
        n_stg[30].res = r_stg[29].neg ? 16'(-mres) : mres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_x.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    `ERFA_ASSERT_SAME(a_out_range, o_erf.valid, ($signed(o_erf.erf_value) <= 16'sd16384) && ($signed(o_erf.erf_value) >= -16'sd16384))
    `ERFA_ASSERT_SAME(a_full_when_blocked, !i_x.ready, (&r_vld) && !o_erf.ready)
    `ERFA_ASSERT_SAME(a_quo_range, r_vld[23], (r_stg[23].quo <= 21'd1048576) && (r_stg[23].quo >= 21'd400000))
    `ERFA_ASSERT_SAME(a_exp_range, r_vld[14], r_stg[14].ex <= 21'd1048576)

endmodule

// File: tb/erfa_checker.sv
// Checker for the error function pipeline: watches both request channels,
// predicts erf(x) in fixed point and compares. Depends on erfa_if.
`timescale 1ns / 1ps

module erfa_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    erfa_x_if.sink     x_ch,
    erfa_erf_if.sink   erf_ch,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);

    localparam longint QONE = 64'd1048576;
    localparam longint QHALF = 64'd524288;
    localparam longint LIM = 16384;
    localparam longint A1 = 267208;
    localparam longint A2 = -298316;
    localparam longint A3 = 1490460;
    localparam longint A4 = -1523740;
    localparam longint A5 = 1112964;
    localparam longint PCOEF = 343504;
    localparam longint LN2Q = 726817;
    localparam longint LOG2EQ = 1512775;
    localparam longint POW2 [8] = '{741455, 881744, 961548, 1004120,
                                     1026107, 1037281, 1042913, 1045741};

    logic signed [15:0] erf_expected_q[$];

    function automatic longint qmul(longint a, longint b);
        longint prod;
        prod = a * b;
        if (prod >= 0) begin
            return (prod + QHALF) >>> 20;
        end
        return -((-prod + QHALF) >>> 20);
    endfunction

    function automatic longint gauss_decay(longint mag);
        longint sq;
        longint v;
        longint n;
        longint f;
        longint e;
        sq = mag * mag;
        v = (sq * LOG2EQ + (64'd1 << 23)) >>> 24;
        n = v >>> 20;
        f = v & 64'hFFFFF;
        e = QONE;
        for (int i = 0; i < 8; i++) begin
            if (f[19 - i]) begin
                e = qmul(e, POW2[i]);
            end
        end
        e = e - qmul(e, qmul(f & 64'hFFF, LN2Q));
        if (n >= 40) begin
            return 0;
        end
        if (n > 0) begin
            e = (e + (64'd1 << (n - 1))) >>> n;
        end
        return e;
    endfunction

    function automatic logic signed [15:0] erf_predict(logic signed [15:0] x);
        longint xs;
        longint mag;
        longint res;
        longint denom;
        longint t;
        longint s;
        longint y;
        xs = x;
        mag = (xs < 0) ? -xs : xs;
        if (mag >= 16384) begin
            res = LIM;
        end else begin
            denom = QONE + ((mag * PCOEF + (64'd1 << 11)) >>> 12);
            t = ((64'd1 << 40) + denom / 2) / denom;
            s = A5;
            s = qmul(s, t) + A4;
            s = qmul(s, t) + A3;
            s = qmul(s, t) + A2;
            s = qmul(s, t) + A1;
            s = qmul(s, t);
            y = QONE - qmul(s, gauss_decay(mag));
            res = (y >= 0) ? ((y + 32) >>> 6) : -((-y + 32) >>> 6);
            if (res < 0) begin
                res = 0;
            end
            if (res > LIM) begin
                res = LIM;
            end
        end
        if (xs < 0) begin
            res = -res;
        end
        return 16'(res);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
    end

    assign o_pending = erf_expected_q.size();

    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (i_rst_n) begin
            if (x_ch.valid && x_ch.ready) begin
                erf_expected_q.push_back(erf_predict(x_ch.x_value));
            end
            if (erf_ch.valid && erf_ch.ready) begin
                o_results++;
                if (erf_expected_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = erf_expected_q.pop_front();
                    if (erf_ch.erf_value !== want) begin
                        report_mismatch($sformatf("erf_value got %0d want %0d",
                                                  erf_ch.erf_value, want));
                    end
                end
            end
        end
    end

endmodule

// File: tb/tb_top.sv
// Top of the error function testbench: clock, reset, request stimulus and verdict.
// Depends on erfa_if, error_function_approx_top and erfa_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int RAND_ITEMS = 1930;
    localparam int STALL_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   results;
    int   idle_cycles;
    int   sent;

    erfa_x_if   x_ch ();
    erfa_erf_if erf_ch ();

    error_function_approx_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_x    (x_ch.sink),
        .o_erf  (erf_ch.source)
    );

    erfa_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .x_ch     (x_ch.sink),
        .erf_ch   (erf_ch.sink),
        .o_errors (errors),
        .o_pending(pending),
        .o_results(results)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task automatic send_request(logic signed [15:0] x);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            x_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        x_ch.valid <= 1'b1;
        x_ch.x_value <= x;
        @(posedge i_clk);
        while (!x_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic signed [15:0] random_x();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return 16'($signed($urandom_range(0, 32767)) - 16384);
        end else if (pick < 8) begin
            return 16'($signed($urandom_range(0, 8191)) - 4096);
        end
        return 16'($urandom);
    endfunction

    initial begin
        logic signed [15:0] directed[$];
        i_rst_n = 1'b0;
        x_ch.valid = 1'b0;
        x_ch.x_value = '0;
        sent = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd16384,
                     -16'sd16384, 16'sd16383, -16'sd16383, 16'sd4096, -16'sd4096,
                     16'sd2048, 16'sd8192, -16'sd12288, 16'sd100, -16'sd100,
                     16'sh5555, 16'shAAAA, 16'sd1000, 16'sd6000};
        foreach (directed[i]) send_request(directed[i]);
        x_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            send_request(random_x());
            if (i == RAND_ITEMS / 2) begin
                x_ch.valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
        end
        x_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d samples across zero, small, mid and saturated arguments;",
                 sent);
        $display("checked %0d erf results with random stalls on both channels.", results);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        int hold;
        erf_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
            if (hold > 0) begin
                erf_ch.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            erf_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!erf_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (x_ch.valid && x_ch.ready) || (erf_ch.valid && erf_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/erfa_pkg.sv
hdl/erfa_if.sv
hdl/error_function_approx_top.sv
tb/erfa_checker.sv
tb/tb_top.sv
